[sv/assert_macros.svh]
// assertion macros used by the cache tag model top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache tag model check failed");

// next-cycle implication, disabled while reset is low
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache tag model check failed");

`endif

[sv/sact_pkg.sv]
// types, geometry constants and helper functions of the cache tag model
package sact_pkg;

    // cache geometry
    localparam int WAYS       = 4;
    localparam int SET_COUNT  = 8;
    localparam int LINE_BYTES = 16;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int HINT_W    = 2;
    localparam int WAY_OUT_W = 2;
    localparam int SET_OUT_W = 3;

    // derived address split
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int IDX_BITS = $clog2(SET_COUNT);
    localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
    localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // input beat
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [HINT_W-1:0] victim_way;
    } sact_req_t;

    // result beat
    typedef struct packed {
        logic                 hit;
        logic                 wrote_back;
        logic [WAY_OUT_W-1:0] way_used;
        logic [SET_OUT_W-1:0] set_used;
        logic [CNT_W-1:0]     load_total;
        logic [CNT_W-1:0]     load_miss_total;
        logic [CNT_W-1:0]     store_total;
        logic [CNT_W-1:0]     store_miss_total;
        logic [CNT_W-1:0]     writeback_total;
    } sact_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } sact_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } sact_state_t;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

    // set index, wrapped into the set range
    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] raw;
        raw = (a >> OFF_BITS) & IDX_MASK;
        if (raw >= ADDR_W'(SET_COUNT))
        begin
            raw = raw - ADDR_W'(SET_COUNT);
        end
        return SET_W'(raw);
    endfunction

    // tag above offset and index
    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
        return TAG_W'(a >> (OFF_BITS + IDX_BITS));
    endfunction

    // victim hint folded into the way range
    function automatic logic [WAY_W-1:0] hint_of(input logic [HINT_W-1:0] h);
        logic [4:0] v;
        v = 5'(h);
        for (int i = 0; i < 3; i++)
        begin
            if (v >= 5'(WAYS))
            begin
                v = v - 5'(WAYS);
            end
        end
        return WAY_W'(v);
    endfunction

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

[sv/sact_ctrl.sv]
// access sequencer of the cache tag model
module sact_ctrl
    import sact_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output sact_cmd_t cmd
);

    sact_state_t state_reg;
    sact_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands and busy
    always_comb
    begin
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_LOOKUP:
            begin
                busy       = 1'b1;
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[sv/sact_dp.sv]
// tag memory, line status bits, counters and result register of the cache tag model
module sact_dp
    import sact_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sact_cmd_t cmd,
    input  sact_req_t req,
    output logic      done,
    output sact_rsp_t rsp
);

    // tag memory, one row of ways per set
    tag_row_t tag_mem [SET_COUNT];
    tag_row_t tag_row_reg;

    // line status bits
    logic [WAYS-1:0] valid_reg [SET_COUNT];
    logic [WAYS-1:0] dirty_reg [SET_COUNT];

    // captured beat
    sact_req_t req_reg;

    // counters
    logic [CNT_W-1:0] loads_reg;
    logic [CNT_W-1:0] load_misses_reg;
    logic [CNT_W-1:0] stores_reg;
    logic [CNT_W-1:0] store_misses_reg;
    logic [CNT_W-1:0] writebacks_reg;
    logic [CNT_W-1:0] loads_next;
    logic [CNT_W-1:0] load_misses_next;
    logic [CNT_W-1:0] stores_next;
    logic [CNT_W-1:0] store_misses_next;
    logic [CNT_W-1:0] writebacks_next;

    sact_rsp_t rsp_reg;
    logic      done_reg;

    // lookup signals
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic [WAYS-1:0]  row_valid;
    logic [WAYS-1:0]  row_dirty;
    logic [WAYS-1:0]  match;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] way;
    logic [WAYS-1:0]  way_bit;
    logic             hit;
    logic             any_free;
    logic             wb;
    logic             is_store;
    logic [WAYS-1:0]  valid_next;
    logic [WAYS-1:0]  dirty_next;
    tag_row_t         tag_row_next;

    // capture the beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    // tag memory: row read on capture, row write on a miss
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_row_reg <= tag_mem[set_of(req.address)];
        end
        if (cmd.commit && !hit)
        begin
            tag_mem[set_idx] <= tag_row_next;
        end
    end

    // compare and pick a way
    always_comb
    begin
        set_idx   = set_of(req_reg.address);
        tag       = tag_of(req_reg.address);
        is_store  = (req_reg.op == OP_STORE);
        row_valid = valid_reg[set_idx];
        row_dirty = dirty_reg[set_idx];
        hit_way   = '0;
        free_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            match[w] = row_valid[w] && (tag_row_reg[w] == tag);
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!row_valid[w])
            begin
                free_way = WAY_W'(w);
            end
        end
        hit      = |match;
        any_free = ~&row_valid;
        if (hit)
        begin
            way = hit_way;
        end
        else if (any_free)
        begin
            way = free_way;
        end
        else
        begin
            way = hint_of(req_reg.victim_way);
        end
        way_bit = WAYS'(1) << way;
        wb      = !hit && row_valid[way] && row_dirty[way];

        valid_next = row_valid | way_bit;
        dirty_next = row_dirty;
        if (!hit)
        begin
            dirty_next = dirty_next & ~way_bit;
        end
        if (is_store)
        begin
            dirty_next = dirty_next | way_bit;
        end

        tag_row_next      = tag_row_reg;
        tag_row_next[way] = tag;
    end

    // counter updates
    always_comb
    begin
        loads_next        = loads_reg;
        load_misses_next  = load_misses_reg;
        stores_next       = stores_reg;
        store_misses_next = store_misses_reg;
        writebacks_next   = wb ? sat_inc(writebacks_reg) : writebacks_reg;
        if (is_store)
        begin
            stores_next = sat_inc(stores_reg);
            if (!hit)
            begin
                store_misses_next = sat_inc(store_misses_reg);
            end
        end
        else
        begin
            loads_next = sat_inc(loads_reg);
            if (!hit)
            begin
                load_misses_next = sat_inc(load_misses_reg);
            end
        end
    end

    // status bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
            end
            loads_reg        <= '0;
            load_misses_reg  <= '0;
            stores_reg       <= '0;
            store_misses_reg <= '0;
            writebacks_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                valid_reg[set_idx] <= valid_next;
                dirty_reg[set_idx] <= dirty_next;
                loads_reg          <= loads_next;
                load_misses_reg    <= load_misses_next;
                stores_reg         <= stores_next;
                store_misses_reg   <= store_misses_next;
                writebacks_reg     <= writebacks_next;
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.hit              <= hit;
            rsp_reg.wrote_back       <= wb;
            rsp_reg.way_used         <= WAY_OUT_W'(way);
            rsp_reg.set_used         <= SET_OUT_W'(set_idx);
            rsp_reg.load_total       <= loads_next;
            rsp_reg.load_miss_total  <= load_misses_next;
            rsp_reg.store_total      <= stores_next;
            rsp_reg.store_miss_total <= store_misses_next;
            rsp_reg.writeback_total  <= writebacks_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[sv/set_assoc_cache_tag_model_top.sv]
// top level of the set-associative write-back cache tag model
//
// An access is taken when start is high and busy is low. The capture edge
// reads the set's tag row from the tag memory into a register; in the lookup
// state the ways are compared, and the edge that leaves it updates tags, status
// bits and counters and loads the result register; busy is high in the lookup
// state. done marks the result for exactly one cycle and cannot be held off,
// so a result must be taken when it shows. A new access may be started in the
// cycle done is high. Valid and dirty bits are flip-flops cleared at reset, so
// the block is ready right after reset.
`include "assert_macros.svh"

module set_assoc_cache_tag_model_top
    import sact_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sact_req_t req,
    output logic      done,
    output sact_rsp_t rsp
);

    sact_cmd_t cmd;

    // sequencer
    sact_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // lookup and update datapath
    sact_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // checks
    `SACT_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)
    `SACT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `SACT_ASSERT_NXT(a_busy_then_done, clk, rst_n, busy, done)
    `SACT_ASSERT_IMP(a_hit_no_writeback, clk, rst_n, done && rsp.hit, !rsp.wrote_back)

endmodule

[bench/set_assoc_cache_tag_model_top_test.sv]
// self-checking testbench of the set-associative write-back cache tag model
`timescale 1ns / 100ps

module set_assoc_cache_tag_model_top_test;
    import sact_pkg::*;

    localparam int LINE_TOTAL = WAYS * SET_COUNT;
    localparam int POOL_SIZE  = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    sact_req_t req;
    logic      done;
    sact_rsp_t rsp;

    // shadow copy of the tag store and counters
    logic             shadow_valid [LINE_TOTAL];
    logic             shadow_dirty [LINE_TOTAL];
    logic [TAG_W-1:0] shadow_tag   [LINE_TOTAL];
    logic [CNT_W-1:0] loads_cnt;
    logic [CNT_W-1:0] load_miss_cnt;
    logic [CNT_W-1:0] stores_cnt;
    logic [CNT_W-1:0] store_miss_cnt;
    logic [CNT_W-1:0] writeback_cnt;

    sact_rsp_t lookup_q [$];
    sact_rsp_t rsp_want;
    sact_rsp_t rsp_pred;

    int  mismatch_cnt;
    int  fail_cnt;
    int  accepted_cnt;
    int  hit_cnt;
    int  evict_cnt;
    int  idle_cycles;
    bit  gaps_on;

    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    set_assoc_cache_tag_model_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // saturating counter step
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // build a byte address from tag, set and offset
    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] t, input int s,
                                                    input int off);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(t) << (OFF_BITS + IDX_BITS);
        a = a | (ADDR_W'(s) << OFF_BITS) | ADDR_W'(off % LINE_BYTES);
        return a;
    endfunction

    // clear the shadow tag store
    task automatic shadow_reset();
        for (int i = 0; i < LINE_TOTAL; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_tag[i]   = '0;
        end
        loads_cnt      = '0;
        load_miss_cnt  = '0;
        stores_cnt     = '0;
        store_miss_cnt = '0;
        writeback_cnt  = '0;
    endtask

    // lookup, fill and count for one access, returning the expected result beat
    task automatic predict_lookup(input sact_req_t r, output sact_rsp_t e);
        logic [ADDR_W-1:0] raw_set;
        logic [TAG_W-1:0]  t;
        int                s;
        int                base;
        int                way;
        bit                is_hit;
        bit                found;
        bit                evicted;
        raw_set = (r.address >> OFF_BITS) & ((ADDR_W'(1) << IDX_BITS) - 1'b1);
        s       = int'(raw_set) % SET_COUNT;
        t       = TAG_W'(r.address >> (OFF_BITS + IDX_BITS));
        base    = s * WAYS;
        way     = 0;
        is_hit  = 1'b0;
        found   = 1'b0;
        evicted = 1'b0;
        // lowest matching valid way
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && shadow_valid[base + w] && shadow_tag[base + w] == t)
            begin
                way    = w;
                is_hit = 1'b1;
                found  = 1'b1;
            end
        end
        // lowest free way
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && !shadow_valid[base + w])
            begin
                way   = w;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            way = int'(r.victim_way) % WAYS;
        end
        // allocate on miss, write back a dirty victim
        if (!is_hit)
        begin
            if (shadow_valid[base + way] && shadow_dirty[base + way])
            begin
                evicted       = 1'b1;
                writeback_cnt = bump(writeback_cnt);
            end
            shadow_valid[base + way] = 1'b1;
            shadow_dirty[base + way] = 1'b0;
            shadow_tag[base + way]   = t;
        end
        if (r.op == OP_STORE)
        begin
            shadow_dirty[base + way] = 1'b1;
            stores_cnt = bump(stores_cnt);
            if (!is_hit)
            begin
                store_miss_cnt = bump(store_miss_cnt);
            end
        end
        else
        begin
            loads_cnt = bump(loads_cnt);
            if (!is_hit)
            begin
                load_miss_cnt = bump(load_miss_cnt);
            end
        end
        e.hit              = is_hit;
        e.wrote_back       = evicted;
        e.way_used         = WAY_OUT_W'(way);
        e.set_used         = SET_OUT_W'(s);
        e.load_total       = loads_cnt;
        e.load_miss_total  = load_miss_cnt;
        e.store_total      = stores_cnt;
        e.store_miss_total = store_miss_cnt;
        e.writeback_total  = writeback_cnt;
        hit_cnt   += is_hit;
        evict_cnt += evicted;
    endtask

    // one field of a result beat against its expectation
    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
            end
        end
    endfunction

    // result checker and access predictor
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (lookup_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: result beat with no access outstanding", $realtime);
            end
            else
            begin
                rsp_want = lookup_q.pop_front();
                check_field("hit", CNT_W'(rsp_want.hit), CNT_W'(rsp.hit));
                check_field("wrote_back", CNT_W'(rsp_want.wrote_back), CNT_W'(rsp.wrote_back));
                check_field("way_used", CNT_W'(rsp_want.way_used), CNT_W'(rsp.way_used));
                check_field("set_used", CNT_W'(rsp_want.set_used), CNT_W'(rsp.set_used));
                check_field("load_total", rsp_want.load_total, rsp.load_total);
                check_field("load_miss_total", rsp_want.load_miss_total, rsp.load_miss_total);
                check_field("store_total", rsp_want.store_total, rsp.store_total);
                check_field("store_miss_total", rsp_want.store_miss_total,
                            rsp.store_miss_total);
                check_field("writeback_total", rsp_want.writeback_total, rsp.writeback_total);
            end
        end
        if (rst_n && start && busy === 1'b0)
        begin
            predict_lookup(req, rsp_pred);
            lookup_q.push_back(rsp_pred);
            accepted_cnt++;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("set_assoc_cache_tag_model_top_test: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one access beat and wait until it is taken
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [HINT_W-1:0] hint);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        req.op         <= op;
        req.address    <= addr;
        req.victim_way <= hint;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and let every outstanding result arrive
    task automatic wait_drain();
        start <= 1'b0;
        while (lookup_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // fills into an empty cache, extreme addresses, hit after fill
    task automatic test_cold_fills();
        send_access(OP_LOAD, 32'h0000_0000, 2'd0);
        send_access(OP_LOAD, 32'hFFFF_FFFF, 2'd3);
        send_access(OP_STORE, 32'h0000_0004, 2'd1);
        send_access(OP_STORE, 32'hFFFF_FFF0, 2'd2);
        send_access(OP_STORE, line_addr(25'h155_5555, 5, 9), 2'd0);
        send_access(OP_LOAD, line_addr(25'h0AA_AAAA, 5, 3), 2'd3);
        wait_drain();
    endtask

    // full set: victim hint on every way, dirty and clean evictions
    task automatic test_full_set_replacement();
        send_access(OP_STORE, line_addr(25'd1, 3, 0), 2'd0);
        send_access(OP_LOAD, line_addr(25'd2, 3, 4), 2'd0);
        send_access(OP_STORE, line_addr(25'd3, 3, 8), 2'd0);
        send_access(OP_LOAD, line_addr(25'd4, 3, 15), 2'd0);
        // set is full now
        send_access(OP_LOAD, line_addr(25'd5, 3, 0), 2'd0);
        send_access(OP_LOAD, line_addr(25'd6, 3, 0), 2'd1);
        send_access(OP_STORE, line_addr(25'd7, 3, 0), 2'd2);
        send_access(OP_STORE, line_addr(25'd8, 3, 0), 2'd3);
        // hits on refilled lines, then evict the dirty ones
        send_access(OP_LOAD, line_addr(25'd7, 3, 1), 2'd0);
        send_access(OP_STORE, line_addr(25'd5, 3, 2), 2'd1);
        send_access(OP_LOAD, line_addr(25'd9, 3, 0), 2'd0);
        send_access(OP_LOAD, line_addr(25'd10, 3, 0), 2'd3);
        send_access(OP_STORE, line_addr(25'd11, 3, 0), 2'd2);
        wait_drain();
    endtask

    // random accesses over a small tag pool so sets fill and hit
    task automatic run_traffic(input int count);
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    tag_pool[i] = TAG_W'($urandom);
                end
            end
            if ($urandom_range(0, 9) < 8)
            begin
                addr = line_addr(tag_pool[$urandom_range(0, POOL_SIZE - 1)],
                                 $urandom_range(0, SET_COUNT - 1),
                                 $urandom_range(0, LINE_BYTES - 1));
            end
            else
            begin
                addr = $urandom;
            end
            send_access(logic'($urandom_range(0, 1)), addr, HINT_W'($urandom_range(0, 3)));
        end
        wait_drain();
    endtask

    // random traffic with gaps on the sending side
    task automatic test_random_with_gaps();
        gaps_on = 1'b1;
        run_traffic(900);
    endtask

    // random traffic at full rate
    task automatic test_random_back_to_back();
        gaps_on = 1'b0;
        run_traffic(330);
    endtask

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        mismatch_cnt   = 0;
        fail_cnt       = 0;
        accepted_cnt   = 0;
        hit_cnt        = 0;
        evict_cnt      = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
        shadow_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cold_fills();
        test_full_set_replacement();
        test_random_with_gaps();
        test_random_back_to_back();

        // let any late beat show up
        repeat (8) @(posedge clk);
        if (lookup_q.size() != 0)
        begin
            fail_cnt += lookup_q.size();
            $display("%0d results never arrived", lookup_q.size());
        end
        fail_cnt += mismatch_cnt;
        $display("covered %0d loads and stores: %0d hits, %0d dirty evictions",
                 accepted_cnt, hit_cnt, evict_cnt);
        $display("field mismatches: %0d", mismatch_cnt);
        if (fail_cnt == 0)
        begin
            $display("set_assoc_cache_tag_model_top_test: clean");
        end
        else
        begin
            $display("set_assoc_cache_tag_model_top_test: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sact_pkg.sv
sv/sact_ctrl.sv
sv/sact_dp.sv
sv/set_assoc_cache_tag_model_top.sv
bench/set_assoc_cache_tag_model_top_test.sv
